@@ design/rpp_pkg.sv @@
// Shared constants, codes and types for the reference-counted page pool.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package rpp_pkg;

  localparam int PAGES    = 256;
  localparam int REF_BITS = 8;

  // Field widths at the ports.
  localparam int PAGE_W   = 9;
  localparam int REFS_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Memory geometry: a page word holds either a link or a count.
  localparam int ADDR_W = $clog2(PAGES);
  localparam int WORD_W = (PAGE_W > REF_BITS) ? PAGE_W : REF_BITS;

  localparam logic [PAGE_W-1:0] NULL_PAGE = PAGE_W'(PAGES);
  localparam logic [WORD_W-1:0] REF_MAX   = WORD_W'((1 << REF_BITS) - 1);

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DROP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;  // latch the command and start the page word read
    logic commit;   // apply the update and load the result registers
  } dp_cmd_t;

endpackage

@@ design/rpp_ctrl.sv @@
// Controller for the page pool: sequences the read and commit of each command
// and owns the result valid flag. Depends on rpp_pkg.
`timescale 1ns / 1ps

module rpp_ctrl
  import rpp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t dp_cmd
);

  state_t state, state_next;
  logic   out_valid_next;
  logic   slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    // The result register can take a new result if it is empty or being drained.
    slot_free      = !out_valid || !out_stall;
    state_next     = state;
    in_stall       = 1'b1;
    dp_cmd.capture = 1'b0;
    dp_cmd.commit  = 1'b0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          dp_cmd.commit  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/rpp_datapath.sv @@
// Datapath for the page pool: page word memory with per-entry valid bits,
// free list registers and result registers. Depends on rpp_pkg.
`timescale 1ns / 1ps

module rpp_datapath
  import rpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             dp_cmd,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [PAGE_W-1:0]   page,
  output logic [PAGE_W-1:0]   page_out,
  output logic [REFS_W-1:0]   refs,
  output logic [PAGE_W-1:0]   free_count,
  output logic [PAGE_W-1:0]   low_water,
  output logic [STATUS_W-1:0] status
);

  // Each memory word is {busy, value}; value is a link when free, a count when busy.
  logic [WORD_W:0]     mem [PAGES];
  logic [PAGES-1:0]    written;

  logic [PAGE_W-1:0]   free_head, free_total, lowest_free;
  logic [CMD_W-1:0]    cmd_q;
  logic [PAGE_W-1:0]   page_q;
  logic [ADDR_W-1:0]   rd_addr, rd_idx;
  logic [WORD_W:0]     rd_data;
  logic                rd_written;

  logic [WORD_W:0]     word;
  logic                busy;
  logic [WORD_W-1:0]   value;
  logic                in_use;
  logic [WORD_W-1:0]   dec_value;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [WORD_W:0]     wr_data;
  logic [PAGE_W-1:0]   free_head_next, free_total_next, lowest_free_next;
  logic [PAGE_W-1:0]   res_page;
  logic [REFS_W-1:0]   res_refs;
  logic [STATUS_W-1:0] res_status;

  assign rd_addr = (cmd == CMD_ALLOC) ? free_head[ADDR_W-1:0] : page[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_q      <= cmd;
      page_q     <= page;
      rd_idx     <= rd_addr;
      rd_data    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // An entry never written still holds its reset link to the next page.
  assign word   = rd_written ? rd_data : {1'b0, WORD_W'(PAGE_W'(rd_idx) + PAGE_W'(1))};
  assign busy   = word[WORD_W];
  assign value  = word[WORD_W-1:0];
  assign in_use = (page_q < NULL_PAGE) && busy;
  assign dec_value = (value == '0) ? '0 : value - WORD_W'(1);

  always_comb begin
    wr_en            = 1'b0;
    wr_addr          = page_q[ADDR_W-1:0];
    wr_data          = '0;
    free_head_next   = free_head;
    free_total_next  = free_total;
    lowest_free_next = lowest_free;
    res_page         = NULL_PAGE;
    res_refs         = '0;
    res_status       = ST_OK;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (free_head >= NULL_PAGE || free_total == '0) begin
          res_status = ST_EMPTY;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = free_head[ADDR_W-1:0];
          wr_data         = {1'b1, WORD_W'(1)};
          free_head_next  = value[PAGE_W-1:0];
          free_total_next = free_total - PAGE_W'(1);
          if (free_total_next < lowest_free) begin
            lowest_free_next = free_total_next;
          end
          res_page = free_head;
          res_refs = REFS_W'(1);
        end
      end
      CMD_READ: begin
        if (in_use) begin
          res_refs = value[REFS_W-1:0];
        end
      end
      CMD_ADD: begin
        if (!in_use) begin
          res_status = ST_BAD;
        end else if (value >= REF_MAX) begin
          res_refs   = value[REFS_W-1:0];
          res_status = ST_SAT;
        end else begin
          wr_en    = 1'b1;
          wr_data  = {1'b1, value + WORD_W'(1)};
          res_refs = REFS_W'(value + WORD_W'(1));
        end
      end
      CMD_DROP: begin
        if (!in_use) begin
          res_status = ST_BAD;
        end else begin
          wr_en    = 1'b1;
          res_refs = dec_value[REFS_W-1:0];
          if (dec_value == '0) begin
            // Last reference gone: push the page back on the free list.
            wr_data         = {1'b0, WORD_W'(free_head)};
            free_head_next  = page_q;
            free_total_next = free_total + PAGE_W'(1);
          end else begin
            wr_data = {1'b1, dec_value};
          end
        end
      end
      default: res_status = ST_OK;
    endcase
    if (!dp_cmd.commit) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= '0;
      free_total  <= NULL_PAGE;
      lowest_free <= NULL_PAGE;
    end else if (dp_cmd.commit) begin
      free_head   <= free_head_next;
      free_total  <= free_total_next;
      lowest_free <= lowest_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.commit) begin
      page_out   <= res_page;
      refs       <= res_refs;
      free_count <= free_total_next;
      low_water  <= lowest_free_next;
      status     <= res_status;
    end
  end

endmodule

@@ design/refcounted_page_pool.sv @@
// Top level of the reference-counted page pool allocator.
// Joins rpp_ctrl and rpp_datapath; depends on rpp_pkg.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  cmd, page
//   result   out        out_valid / out_stall page_out, refs, free_count,
//                                            low_water, status
//
// Each command has two steps: the first reads its page word from the single
// memory read port, the second computes and writes the update back.
// A new command is taken while the previous result still waits in the output
// register; its commit then waits until that register drains.
// Reset is synchronous and takes effect at once: per-entry written bits stand
// in for the initial free list, so there is no clearing pass.
`timescale 1ns / 1ps

module refcounted_page_pool
  import rpp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [PAGE_W-1:0]   page,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PAGE_W-1:0]   page_out,
  output logic [REFS_W-1:0]   refs,
  output logic [PAGE_W-1:0]   free_count,
  output logic [PAGE_W-1:0]   low_water,
  output logic [STATUS_W-1:0] status
);

  dp_cmd_t dp_cmd;

  rpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  rpp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .cmd        (cmd),
    .page       (page),
    .page_out   (page_out),
    .refs       (refs),
    .free_count (free_count),
    .low_water  (low_water),
    .status     (status)
  );

endmodule

@@ verif/refcounted_page_pool_test.sv @@
// Self-checking testbench for refcounted_page_pool: directed table, then random traffic.
// Results are checked against the known table results or an in-bench model of the free list and counts.
// Depends on rpp_pkg and the design files.
`timescale 1ns / 1ps

module refcounted_page_pool_test
  import rpp_pkg::*;
;

  localparam int QUIET_LIMIT = 4000;
  localparam int PRINT_CAP   = 40;
  localparam int DIR_N       = 22;

  typedef struct packed {
    logic [PAGE_W-1:0]   pg_out;
    logic [REFS_W-1:0]   count;
    logic [PAGE_W-1:0]   free_n;
    logic [PAGE_W-1:0]   low_n;
    logic [STATUS_W-1:0] code;
  } pool_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [PAGE_W-1:0] pg;
    logic              known;
    pool_result_t      res;
  } dir_row_t;

  // Rows marked known carry their result; the rest are checked by the model.
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{CMD_ALLOC, 9'h1FF,    1'b1, {9'd0,      8'd1, 9'd255, 9'd255, ST_OK}},
    '{CMD_ALLOC, 9'h000,    1'b1, {9'd1,      8'd1, 9'd254, 9'd254, ST_OK}},
    '{CMD_ADD,   9'd0,      1'b1, {NULL_PAGE, 8'd2, 9'd254, 9'd254, ST_OK}},
    '{CMD_READ,  9'd0,      1'b1, {NULL_PAGE, 8'd2, 9'd254, 9'd254, ST_OK}},
    '{CMD_READ,  NULL_PAGE, 1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_OK}},
    '{CMD_READ,  9'h1FF,    1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_OK}},
    '{CMD_READ,  9'd2,      1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_OK}},
    '{CMD_ADD,   NULL_PAGE, 1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_BAD}},
    '{CMD_DROP,  9'h1FF,    1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_BAD}},
    '{CMD_ADD,   9'd5,      1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_BAD}},
    '{CMD_DROP,  9'd255,    1'b1, {NULL_PAGE, 8'd0, 9'd254, 9'd254, ST_BAD}},
    '{CMD_DROP,  9'd1,      1'b1, {NULL_PAGE, 8'd0, 9'd255, 9'd254, ST_OK}},
    '{CMD_ALLOC, 9'd0,      1'b1, {9'd1,      8'd1, 9'd254, 9'd254, ST_OK}},
    '{CMD_DROP,  9'd0,      1'b1, {NULL_PAGE, 8'd1, 9'd254, 9'd254, ST_OK}},
    '{CMD_DROP,  9'd0,      1'b1, {NULL_PAGE, 8'd0, 9'd255, 9'd254, ST_OK}},
    '{CMD_DROP,  9'd0,      1'b1, {NULL_PAGE, 8'd0, 9'd255, 9'd254, ST_BAD}},
    '{CMD_READ,  9'd0,      1'b1, {NULL_PAGE, 8'd0, 9'd255, 9'd254, ST_OK}},
    '{CMD_ALLOC, 9'h155,    1'b1, {9'd0,      8'd1, 9'd254, 9'd254, ST_OK}},
    '{CMD_ADD,   9'd1,      1'b0, '0},
    '{CMD_ADD,   9'd1,      1'b0, '0},
    '{CMD_READ,  9'd1,      1'b0, '0},
    '{CMD_READ,  9'd170,    1'b0, '0}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd = CMD_ALLOC;
  logic [PAGE_W-1:0]   page = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PAGE_W-1:0]   page_out;
  logic [REFS_W-1:0]   refs;
  logic [PAGE_W-1:0]   free_count;
  logic [PAGE_W-1:0]   low_water;
  logic [STATUS_W-1:0] status;

  refcounted_page_pool dut (.*);

  // Model of the pool.
  logic [PAGE_W-1:0] pool_head;
  logic [PAGE_W-1:0] pool_free;
  logic [PAGE_W-1:0] pool_low;
  logic [WORD_W-1:0] pool_word [PAGES];
  logic              pool_busy [PAGES];

  pool_result_t pending_results [$];
  logic         row_known = 1'b0;
  pool_result_t row_result = '0;
  int           src_idle_pct = 0;
  int           sink_stall_pct = 0;
  int           fault_count = 0;
  int           quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic pool_reset();
    for (int i = 0; i < PAGES; i++) begin
      pool_word[i] = WORD_W'(i + 1);
      pool_busy[i] = 1'b0;
    end
    pool_head = '0;
    pool_free = PAGE_W'(PAGES);
    pool_low  = PAGE_W'(PAGES);
  endtask

  function automatic pool_result_t pool_apply(input logic [CMD_W-1:0] op,
                                              input logic [PAGE_W-1:0] pg);
    pool_result_t res;
    logic [ADDR_W-1:0] hd;
    logic [ADDR_W-1:0] idx;
    logic [WORD_W-1:0] cnt;
    logic live;
    res = '0;
    res.pg_out = NULL_PAGE;
    res.code = ST_OK;
    hd = pool_head[ADDR_W-1:0];
    idx = pg[ADDR_W-1:0];
    live = (pg < PAGES) && pool_busy[idx];
    case (op)
      CMD_ALLOC: begin
        if (pool_head >= PAGES || pool_free == '0) begin
          res.code = ST_EMPTY;
        end else begin
          res.pg_out = pool_head;
          res.count = REFS_W'(1);
          pool_head = PAGE_W'(pool_word[hd]);
          pool_word[hd] = WORD_W'(1);
          pool_busy[hd] = 1'b1;
          pool_free = pool_free - PAGE_W'(1);
          if (pool_free < pool_low) pool_low = pool_free;
        end
      end
      CMD_READ: begin
        if (live) res.count = pool_word[idx][REFS_W-1:0];
      end
      default: begin
        if (!live) begin
          res.code = ST_BAD;
        end else if (op == CMD_ADD) begin
          if (pool_word[idx] >= REF_MAX) begin
            res.code = ST_SAT;
          end else begin
            pool_word[idx] = pool_word[idx] + WORD_W'(1);
          end
          res.count = pool_word[idx][REFS_W-1:0];
        end else begin
          cnt = (pool_word[idx] == '0) ? '0 : pool_word[idx] - WORD_W'(1);
          // The last reference returns the page to the head of the free list.
          if (cnt == '0) begin
            pool_word[idx] = WORD_W'(pool_head);
            pool_busy[idx] = 1'b0;
            pool_head = pg;
            pool_free = pool_free + PAGE_W'(1);
          end else begin
            pool_word[idx] = cnt;
          end
          res.count = cnt[REFS_W-1:0];
        end
      end
    endcase
    res.free_n = pool_free;
    res.low_n = pool_low;
    return res;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_busy();
    int n;
    int k;
    n = PAGES - int'(pool_free);
    if (n <= 0) return NULL_PAGE;
    k = $urandom_range(n - 1);
    for (int i = 0; i < PAGES; i++) begin
      if (pool_busy[i]) begin
        if (k == 0) return PAGE_W'(i);
        k--;
      end
    end
    return NULL_PAGE;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 55) return pick_busy();
    if (r < 65) return NULL_PAGE;
    if (r < 75) return PAGE_W'($urandom_range(PAGES + 1, (1 << PAGE_W) - 1));
    return PAGE_W'($urandom);
  endfunction

  task automatic report(input string msg);
    if (fault_count < PRINT_CAP) $display("MISMATCH: %s", msg);
    fault_count++;
  endtask

  task automatic compare_result(input pool_result_t got, input pool_result_t want);
    if (got.pg_out !== want.pg_out)
      report($sformatf("page_out %0d, expected %0d", got.pg_out, want.pg_out));
    if (got.count !== want.count)
      report($sformatf("refs %0d, expected %0d", got.count, want.count));
    if (got.free_n !== want.free_n)
      report($sformatf("free_count %0d, expected %0d", got.free_n, want.free_n));
    if (got.low_n !== want.low_n)
      report($sformatf("low_water %0d, expected %0d", got.low_n, want.low_n));
    if (got.code !== want.code)
      report($sformatf("status %0d, expected %0d", got.code, want.code));
  endtask

  // Results are taken before commands so that ordering within an edge is fixed.
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t calc;
    logic moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        got = {page_out, refs, free_count, low_water, status};
        if (pending_results.size() == 0) report("result transaction with nothing pending");
        else compare_result(got, pending_results.pop_front());
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        calc = pool_apply(cmd, page);
        pending_results.push_back(row_known ? row_result : calc);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("refcounted_page_pool verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < sink_stall_pct);

  // Every driving task starts and ends at a falling edge with the model up to date.
  task automatic launch();
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drive(input logic [CMD_W-1:0] op, input logic [PAGE_W-1:0] pg,
                       input logic known, input pool_result_t res);
    row_known = known;
    row_result = res;
    in_valid <= 1'b1;
    cmd <= op;
    page <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input logic [CMD_W-1:0] op, input logic [PAGE_W-1:0] pg);
    drive(op, pg, 1'b0, '0);
  endtask

  task automatic mixed_txn();
    int r;
    logic [CMD_W-1:0] op;
    launch();
    r = $urandom_range(99);
    op = (r < 30) ? CMD_ALLOC : (r < 55) ? CMD_ADD : (r < 85) ? CMD_DROP : CMD_READ;
    send_random(op, pick_page());
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Allocate one page and add references (with occasional reads) until the count saturates, then send three more.
  task automatic saturate_page();
    logic [PAGE_W-1:0] tgt;
    int extra;
    int guard;
    extra = 0;
    guard = 0;
    launch();
    tgt = pool_head;
    send_random(CMD_ALLOC, PAGE_W'($urandom));
    while (extra < 3 && guard < 400) begin
      launch();
      if (tgt < PAGES && pool_word[tgt[ADDR_W-1:0]] == REF_MAX) extra++;
      send_random(($urandom_range(7) == 0) ? CMD_READ : CMD_ADD, tgt);
      guard++;
    end
  endtask

  task automatic fill_pool();
    while (pool_free != '0) begin
      launch();
      send_random(CMD_ALLOC, PAGE_W'($urandom));
    end
    repeat (3) begin
      launch();
      send_random(CMD_ALLOC, PAGE_W'($urandom));
    end
  endtask

  task automatic empty_pool();
    while (pool_free != PAGES) begin
      launch();
      send_random(CMD_DROP, pick_busy());
    end
  endtask

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    pool_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      launch();
      drive(DIR_ROWS[i].op, DIR_ROWS[i].pg, DIR_ROWS[i].known, DIR_ROWS[i].res);
    end
    drain_pending();

    // Back-to-back traffic through saturation, an empty pool and a full release, then mixed commands.
    saturate_page();
    fill_pool();
    empty_pool();
    repeat (150) mixed_txn();
    drain_pending();

    set_idling(86, 0);
    repeat (175) mixed_txn();
    drain_pending();

    set_idling(0, 86);
    repeat (175) mixed_txn();

    set_idling(37, 37);
    repeat (175) mixed_txn();

    drain_pending();
    repeat (10) @(posedge clk);
    if (fault_count == 0) begin
      $display("refcounted_page_pool verification clean");
    end else begin
      $display("refcounted_page_pool verification failed");
    end
    $finish;
  end

endmodule
